FILE: hw/rtl/tssm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tssm_pkg
// shared constants and types for the two-stacks shared memory block
// ----------------------------------------------------------------------------
package tssm_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    localparam logic [1:0] CMD_PUSH_ONE = 2'd0;
    localparam logic [1:0] CMD_PUSH_TWO = 2'd1;
    localparam logic [1:0] CMD_POP_ONE  = 2'd2;
    localparam logic [1:0] CMD_POP_TWO  = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming beat
        logic exec;   // run the captured command against memory and counts
    } tssm_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tssm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tssm_ctrl
// sequencer: capture, execute, then present the result for one cycle
// ----------------------------------------------------------------------------
module tssm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    output tssm_pkg::tssm_cmd_t    dp_cmd
);
    import tssm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign busy   = (state_reg == ST_EXEC);
    assign accept = start && !busy;
    assign done   = (state_reg == ST_RESP);

    always_comb
    begin
        dp_cmd.load = accept;
        dp_cmd.exec = (state_reg == ST_EXEC);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // a new beat may enter while the result is shown
                state_next = accept ? ST_EXEC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tssm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tssm_datapath
// word memory, stack counts and result registers
// ----------------------------------------------------------------------------
module tssm_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tssm_pkg::tssm_cmd_t           dp_cmd,
    input  wire logic [1:0]                    command,
    input  wire logic signed [tssm_pkg::WORD_W-1:0] push_value,
    output logic signed [tssm_pkg::WORD_W-1:0] pop_value,
    output logic [1:0]                         status
);
    import tssm_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    logic [1:0]        cmd_reg;
    logic [WORD_W-1:0] value_reg;
    logic [CNT_W-1:0]  count_one_reg;
    logic [CNT_W-1:0]  count_one_next;
    logic [CNT_W-1:0]  count_two_reg;
    logic [CNT_W-1:0]  count_two_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic              pop_ok_reg;
    logic              pop_ok_next;
    logic [WORD_W-1:0] rd_data_reg;

    logic              full;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  top_two_push;
    logic [CNT_W-1:0]  top_two_pop;

    assign full = ((count_one_reg + count_two_reg) >= CNT_W'(DEPTH));
    // stack two lives at the high end, growing down
    assign top_two_push = CNT_W'(DEPTH - 1) - count_two_reg;
    assign top_two_pop  = CNT_W'(DEPTH) - count_two_reg;

    always_comb
    begin
        count_one_next = count_one_reg;
        count_two_next = count_two_reg;
        status_next    = STAT_OK;
        pop_ok_next    = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        addr           = '0;
        case (cmd_reg)
            CMD_PUSH_ONE:
            begin
                addr = count_one_reg[ADDR_W-1:0];
                if (full)
                    status_next = STAT_FULL;
                else
                begin
                    wr_en          = 1'b1;
                    count_one_next = count_one_reg + CNT_W'(1);
                end
            end
            CMD_PUSH_TWO:
            begin
                addr = top_two_push[ADDR_W-1:0];
                if (full)
                    status_next = STAT_FULL;
                else
                begin
                    wr_en          = 1'b1;
                    count_two_next = count_two_reg + CNT_W'(1);
                end
            end
            CMD_POP_ONE:
            begin
                count_one_next = count_one_reg - CNT_W'(1);
                addr           = count_one_next[ADDR_W-1:0];
                if (count_one_reg == '0)
                begin
                    status_next    = STAT_EMPTY;
                    count_one_next = count_one_reg;
                end
                else
                begin
                    rd_en       = 1'b1;
                    pop_ok_next = 1'b1;
                end
            end
            CMD_POP_TWO:
            begin
                addr = top_two_pop[ADDR_W-1:0];
                if (count_two_reg == '0)
                    status_next = STAT_EMPTY;
                else
                begin
                    rd_en          = 1'b1;
                    pop_ok_next    = 1'b1;
                    count_two_next = count_two_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec && wr_en)
            mem[addr] <= value_reg;
        if (dp_cmd.exec && rd_en)
            rd_data_reg <= mem[addr];
        if (dp_cmd.load)
        begin
            cmd_reg   <= command;
            value_reg <= push_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_one_reg <= '0;
            count_two_reg <= '0;
            status_reg    <= STAT_OK;
            pop_ok_reg    <= 1'b0;
        end
        else if (dp_cmd.exec)
        begin
            count_one_reg <= count_one_next;
            count_two_reg <= count_two_next;
            status_reg    <= status_next;
            pop_ok_reg    <= pop_ok_next;
        end
    end

    assign pop_value = pop_ok_reg ? rd_data_reg : '1;
    assign status    = status_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/two_stacks_shared_memory_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_stacks_shared_memory_top
// two lifo stacks sharing one word memory, one growing up, one growing down
// ----------------------------------------------------------------------------
// usage
//   input beat: command and push_value are taken at a rising edge where start
//   is high and busy is low. command selects push or pop on stack one or two.
//   result beat: pop_value and status are valid for exactly one cycle while
//   done is high; there is no back-pressure, the receiver must take it then.
//   sequence: the accepting edge captures the beat; the memory is accessed in
//   the execute state, and done rises with the registered read data and
//   status on the ports in the response state.
//   overlap: busy is high for the one cycle in which the memory port is in
//   use, and a new beat may be accepted in the same cycle the previous result
//   is shown.
//   a push answers pop_value all ones; a refused push answers status full,
//   a pop on an empty stack answers status empty and pop_value all ones.
//   reset: rst_n clears both stack counts and the sequencer; memory contents
//   are not cleared and need not be, since a pop only reads pushed words.
// ----------------------------------------------------------------------------
module two_stacks_shared_memory_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          command,
    input  wire logic signed [tssm_pkg::WORD_W-1:0]  push_value,
    output logic                                     done,
    output logic signed [tssm_pkg::WORD_W-1:0]       pop_value,
    output logic [1:0]                               status
);
    import tssm_pkg::*;

    tssm_cmd_t dp_cmd;

    tssm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .dp_cmd (dp_cmd)
    );

    tssm_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .command    (command),
        .push_value (push_value),
        .pop_value  (pop_value),
        .status     (status)
    );

endmodule

`default_nettype wire
